// ===== src/buart_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// buart_pkg: shared types for the buffered UART FIFO block
// Beat payloads for the command and result channels, and fixed constants.
// ----------------------------------------------------------------------------
package buart_pkg;

	typedef enum logic [1:0] {
		MODE_HOST_WR   = 2'd0,
		MODE_HOST_RD   = 2'd1,
		MODE_LINE_RX   = 2'd2,
		MODE_LINE_DONE = 2'd3
	} mode_t;

	localparam logic [31:0] MAGIC_RESET = 32'h1234_5678;

	typedef struct packed {
		mode_t      mode;
		logic [7:0] data_byte;
	} cmd_t;

	typedef struct packed {
		logic [7:0] host_byte;
		logic       host_ok;
		logic [7:0] line_byte;
		logic       line_send;
		logic       reboot_request;
		logic [4:0] rx_level;
		logic [4:0] tx_level;
	} res_t;

endpackage

// ===== src/buffered_uart_fifo_with_magic_reboot.sv =====
`timescale 1ns / 1ps
// An accepted command beat passes through stage 1, then the result register.
// Throughput: one command beat per cycle while res_ready drains results; FIFO state and
// the magic detector update at the accepting edge, RAM read data lands in stage 1.
// Reset (arst_n low, asynchronous): both FIFOs empty, line idle, detector at position
// zero, magic word back to 0x12345678. FIFO RAM contents are not cleared.
// ----------------------------------------------------------------------------
// buffered_uart_fifo_with_magic_reboot: host/line UART FIFO pair
// Transmit and receive ring FIFOs between host and serial line, with a
// four-byte magic sequence detector on received bytes raising a reboot pulse.
// ----------------------------------------------------------------------------
module buffered_uart_fifo_with_magic_reboot #(
	parameter int FIFO_DEPTH = 16
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cmd_valid,
	output logic              cmd_ready,
	input  buart_pkg::cmd_t   cmd,
	output logic              res_valid,
	input  logic              res_ready,
	output buart_pkg::res_t   res,
	input  logic              cfg_we,
	input  logic [31:0]       cfg_wdata
);
	import buart_pkg::*;

	// Pointer width indexes the RAM exactly; counts must also hold FIFO_DEPTH.
	localparam int PW = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1;
	localparam int CW = $clog2(FIFO_DEPTH + 1);
	localparam logic [PW-1:0] PTR_LAST = PW'(FIFO_DEPTH - 1);
	localparam logic [CW-1:0] CNT_FULL = CW'(FIFO_DEPTH);

	// Stage 1 control, captured at the accepting edge.
	typedef struct packed {
		logic       wr_ok;
		logic       rd_ok;
		logic       send;
		logic       tx_byp;
		logic       reboot;
		logic [7:0] data_byte;
		logic [4:0] rx_level;
		logic [4:0] tx_level;
	} s1_ctl_t;

	// ------------------------------------------------------------------
	// Architectural state
	// ------------------------------------------------------------------
	logic [7:0]    tx_mem [FIFO_DEPTH];
	logic [7:0]    rx_mem [FIFO_DEPTH];
	logic [PW-1:0] tx_rd_q, tx_wr_q, rx_rd_q, rx_wr_q;
	logic [CW-1:0] tx_count_q, rx_count_q;
	logic          line_busy_q;
	logic [1:0]    match_pos_q;
	logic [31:0]   magic_q;

	logic          valid_s1;
	s1_ctl_t       ctl_s1;
	logic [7:0]    tx_rdata_s1, rx_rdata_s1;

	// ------------------------------------------------------------------
	// Handshake: two-deep pipe, each stage moves when the next can take it
	// ------------------------------------------------------------------
	logic accept, adv_s1, out_free;

	assign out_free  = !res_valid || res_ready;
	assign adv_s1    = valid_s1 && out_free;
	assign cmd_ready = !valid_s1 || adv_s1;
	assign accept    = cmd_valid && cmd_ready;

	// ------------------------------------------------------------------
	// Next-state decode for one beat
	// ------------------------------------------------------------------
	logic          tx_push, tx_pop, rx_push, rx_pop;
	logic          busy_d, tx_byp;
	logic [CW-1:0] tx_after_push, tx_count_d, rx_count_d;
	logic [7:0]    want;
	logic          hit, reboot;
	logic [1:0]    match_pos_d;
	logic [31:0]   tx_count_w, rx_count_w;

	always_comb begin
		tx_push = 1'b0;
		tx_pop  = 1'b0;
		rx_push = 1'b0;
		rx_pop  = 1'b0;
		busy_d  = line_busy_q;
		tx_byp  = 1'b0;
		reboot  = 1'b0;
		match_pos_d = match_pos_q;

		// Current magic byte: first byte sits in the top eight bits.
		case (match_pos_q)
			2'd0:    want = magic_q[31:24];
			2'd1:    want = magic_q[23:16];
			2'd2:    want = magic_q[15:8];
			default: want = magic_q[7:0];
		endcase
		hit = (cmd.data_byte == want);

		tx_after_push = tx_count_q;

		unique case (cmd.mode)
			MODE_HOST_WR: begin
				// Full FIFO rejects the byte; an idle line still starts the oldest one.
				tx_push = (tx_count_q != CNT_FULL);
				tx_after_push = tx_count_q + CW'(tx_push);
				tx_pop  = !line_busy_q && (tx_after_push != '0);
				// Empty FIFO with idle line: the new byte goes straight out.
				tx_byp  = tx_pop && (tx_count_q == '0);
				if (tx_pop) begin
					busy_d = 1'b1;
				end
			end
			MODE_HOST_RD: begin
				rx_pop = (rx_count_q != '0);
			end
			MODE_LINE_RX: begin
				// Dropped when full, but the detector still sees it.
				rx_push = (rx_count_q != CNT_FULL);
				// A mismatch goes to zero without retrying this byte as the first.
				if (hit && match_pos_q == 2'd3) begin
					reboot = 1'b1;
					match_pos_d = 2'd0;
				end else if (hit) begin
					match_pos_d = match_pos_q + 2'd1;
				end else begin
					match_pos_d = 2'd0;
				end
			end
			MODE_LINE_DONE: begin
				// Applies even if the line was not marked busy.
				tx_pop = (tx_count_q != '0);
				busy_d = tx_pop;
			end
			default: begin
			end
		endcase

		tx_count_d = tx_count_q + CW'(tx_push) - CW'(tx_pop);
		rx_count_d = rx_count_q + CW'(rx_push) - CW'(rx_pop);
		tx_count_w = 32'(tx_count_d);
		rx_count_w = 32'(rx_count_d);
	end

	// ------------------------------------------------------------------
	// Control state
	// ------------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tx_rd_q     <= '0;
			tx_wr_q     <= '0;
			rx_rd_q     <= '0;
			rx_wr_q     <= '0;
			tx_count_q  <= '0;
			rx_count_q  <= '0;
			line_busy_q <= 1'b0;
			match_pos_q <= 2'd0;
			magic_q     <= MAGIC_RESET;
			valid_s1    <= 1'b0;
			res_valid   <= 1'b0;
		end else begin
			if (cfg_we) begin
				magic_q <= cfg_wdata;
			end
			if (accept) begin
				if (tx_push) begin
					tx_wr_q <= (tx_wr_q == PTR_LAST) ? '0 : tx_wr_q + PW'(1);
				end
				if (tx_pop) begin
					tx_rd_q <= (tx_rd_q == PTR_LAST) ? '0 : tx_rd_q + PW'(1);
				end
				if (rx_push) begin
					rx_wr_q <= (rx_wr_q == PTR_LAST) ? '0 : rx_wr_q + PW'(1);
				end
				if (rx_pop) begin
					rx_rd_q <= (rx_rd_q == PTR_LAST) ? '0 : rx_rd_q + PW'(1);
				end
				tx_count_q  <= tx_count_d;
				rx_count_q  <= rx_count_d;
				line_busy_q <= busy_d;
				match_pos_q <= match_pos_d;
			end
			if (cmd_ready) begin
				valid_s1 <= cmd_valid;
			end
			if (out_free) begin
				res_valid <= valid_s1;
			end
		end
	end

	// ------------------------------------------------------------------
	// FIFO RAMs: one write port and one registered read port each.
	// Read and write never hit the same entry in one cycle except the
	// empty-FIFO pass-through, which is handled by tx_byp.
	// ------------------------------------------------------------------
	always_ff @(posedge clk) begin
		if (accept && tx_push) begin
			tx_mem[tx_wr_q] <= cmd.data_byte;
		end
		if (accept && tx_pop) begin
			tx_rdata_s1 <= tx_mem[tx_rd_q];
		end
	end

	always_ff @(posedge clk) begin
		if (accept && rx_push) begin
			rx_mem[rx_wr_q] <= cmd.data_byte;
		end
		if (accept && rx_pop) begin
			rx_rdata_s1 <= rx_mem[rx_rd_q];
		end
	end

	// Stage 1 payload
	always_ff @(posedge clk) begin
		if (accept) begin
			ctl_s1.wr_ok     <= (cmd.mode == MODE_HOST_WR) && tx_push;
			ctl_s1.rd_ok     <= rx_pop;
			ctl_s1.send      <= tx_pop;
			ctl_s1.tx_byp    <= tx_byp;
			ctl_s1.reboot    <= reboot;
			ctl_s1.data_byte <= cmd.data_byte;
			ctl_s1.rx_level  <= rx_count_w[4:0];
			ctl_s1.tx_level  <= tx_count_w[4:0];
		end
	end

	// ------------------------------------------------------------------
	// Result register
	// ------------------------------------------------------------------
	always_ff @(posedge clk) begin
		if (adv_s1) begin
			res.host_byte      <= ctl_s1.rd_ok ? rx_rdata_s1 : 8'd0;
			res.host_ok        <= ctl_s1.wr_ok || ctl_s1.rd_ok;
			res.line_byte      <= !ctl_s1.send ? 8'd0 :
			                      ctl_s1.tx_byp ? ctl_s1.data_byte : tx_rdata_s1;
			res.line_send      <= ctl_s1.send;
			res.reboot_request <= ctl_s1.reboot;
			res.rx_level       <= ctl_s1.rx_level;
			res.tx_level       <= ctl_s1.tx_level;
		end
	end

	// ------------------------------------------------------------------
	// Assertions
	// ------------------------------------------------------------------
	a_tx_bound: assert property (@(posedge clk) disable iff (!arst_n)
		tx_count_q <= CNT_FULL)
		else $error("tx fill count beyond depth");

	a_rx_bound: assert property (@(posedge clk) disable iff (!arst_n)
		rx_count_q <= CNT_FULL)
		else $error("rx fill count beyond depth");

	a_send_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && ctl_s1.send) |-> line_busy_q)
		else $error("byte started but line not marked busy");

	a_reboot_pos: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && ctl_s1.reboot) |-> (match_pos_q == 2'd0))
		else $error("detector not rewound after completion");

	a_pass_through: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && cmd.mode == MODE_HOST_WR && tx_count_q == '0 && !line_busy_q)
		|=> (tx_count_q == '0 && line_busy_q))
		else $error("idle-line write to empty FIFO did not pass straight out");

endmodule
